/* src/imbl_pkg.sv */
package imbl_pkg;

  localparam int unsigned MAX_COLS   = 128;
  localparam int unsigned MAX_ROWS   = 128;
  localparam int unsigned PLANES     = 4;
  localparam int unsigned FRAC_BITS  = 8;
  localparam int unsigned STORE_DEPTH = PLANES * MAX_ROWS * MAX_COLS;
  localparam int unsigned ADDR_W     = $clog2(STORE_DEPTH);

  typedef enum logic [1:0] {
    CFG_MAP_WIDTH   = 2'd0,
    CFG_MAP_HEIGHT  = 2'd1,
    CFG_PERIODIC    = 2'd2,
    CFG_INTERPOLATE = 2'd3
  } cfg_index_e;

  typedef enum logic [0:0] {
    MODE_WRITE = 1'b0,
    MODE_QUERY = 1'b1
  } mode_e;

  typedef struct packed {
    logic               mode;
    logic [1:0]         plane;
    logic [6:0]         write_col;
    logic [6:0]         write_row;
    logic [31:0]        write_value;
    logic signed [23:0] coord_x;
    logic signed [23:0] coord_y;
  } in_item_t;

  typedef struct packed {
    logic [31:0] map_value;
    logic        outside_map;
  } out_item_t;

endpackage

/* src/image_map_bilinear_lookup_top.sv */
// Bilinear lookup over four stored 128 x 128 planes of 32-bit pixels.
// Input channel (in_valid_i / in_stall_o / in_item_i) carries write items
// and query items. An item is taken when valid is high and stall is low.
// A write item stores one pixel and gives no result; writes flow at one
// item per cycle while the engine is idle. A query item gives one result
// item on the output channel (out_valid_o / out_stall_i / out_item_o).
// Queries are handled one at a time from a one-entry input buffer, so the
// next item is taken while the current query works. A query leaves the
// buffer, runs a serial modulo reduction in periodic mode, passes a border
// check, makes one or four reads of the pixel memory read port (one per
// cycle), drains the multiply-accumulate pipeline and loads the output
// register. A query outside the map skips the reads and the drain.
// Reset clears the control state and sets the registers to width 128,
// height 128, non-periodic, interpolation on; pixel contents stay
// undefined until written. A stalled result holds in the output register
// while the next item waits in the input buffer.
module image_map_bilinear_lookup_top
  import imbl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_item_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_item_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MOD   = 6'b000010,
    S_CHK   = 6'b000100,
    S_RD    = 6'b001000,
    S_DRAIN = 6'b010000,
    S_FIN   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [7:0] w_q, h_q;
  logic       per_q, interp_q;
  logic [7:0] weff, heff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q      <= 8'd128;
      h_q      <= 8'd128;
      per_q    <= 1'b0;
      interp_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_MAP_WIDTH:   w_q      <= cfg_data_i;
        CFG_MAP_HEIGHT:  h_q      <= cfg_data_i;
        CFG_PERIODIC:    per_q    <= cfg_data_i[0];
        CFG_INTERPOLATE: interp_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    weff = (w_q == 8'd0) ? 8'd1 : ((w_q > 8'(MAX_COLS)) ? 8'(MAX_COLS) : w_q);
    heff = (h_q == 8'd0) ? 8'd1 : ((h_q > 8'(MAX_ROWS)) ? 8'(MAX_ROWS) : h_q);
  end

  in_item_t buf_q;
  logic     buf_valid_q;
  logic     take;

  assign take       = buf_valid_q && (state_q == S_IDLE);
  assign in_stall_o = buf_valid_q && !take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      buf_valid_q <= 1'b1;
    end else if (take) begin
      buf_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      buf_q <= in_item_i;
    end
  end

  logic [31:0]       mem [STORE_DEPTH];
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [31:0]       rd_q;

  assign mem_we    = take && (buf_q.mode == MODE_WRITE);
  assign mem_waddr = {buf_q.plane, buf_q.write_row, buf_q.write_col};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= buf_q.write_value;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  logic signed [23:0] xv_q, yv_q;
  logic [1:0]         plane_q;
  logic [23:0]        v_q;
  logic [7:0]         r_q;
  logic [2:0]         mcnt_q;
  logic [7:0]         r_next;
  logic [8:0]         r_tmp;

  always_comb begin
    r_next = r_q;
    r_tmp  = 9'd0;
    for (int i = 0; i < 4; i++) begin
      r_tmp = {r_next, v_q[23 - i]};
      if (r_tmp >= {1'b0, weff}) begin
        r_tmp = r_tmp - {1'b0, weff};
      end
      r_next = r_tmp[7:0];
    end
  end

  logic [6:0] row0_q, row1_q, col0_q, col1_q;
  logic [8:0] ta_q, tb_q, ua_q, ub_q;
  logic [1:0] k_q, last_q;
  logic       res_out_q, res_zero_q;

  logic [15:0] xs, ys, xr, yr;
  logic [7:0]  ix, iy, cxp, cyp, cx, left;
  logic [16:0] hix, hiy;
  logic        outside, near_zero, interp_ok;

  always_comb begin
    xs  = xv_q[15:0];
    ys  = yv_q[15:0];
    hix = {1'b0, weff, 8'd0} + 17'd128;
    hiy = {1'b0, heff, 8'd0} + 17'd128;
    outside = (!per_q && ((xv_q < 24'sd128) || ($signed({1'b0, xv_q}) >
                $signed({8'd0, hix})))) ||
              (yv_q < 24'sd128) ||
              ($signed({1'b0, yv_q}) > $signed({8'd0, hiy}));
    ix  = xs[15:8];
    iy  = ys[15:8];
    xr  = xs + 16'd128;
    yr  = ys + 16'd128;
    cxp = xr[15:8];
    cyp = yr[15:8];
    cx  = (cxp == 8'd0) ? 8'd0 : cxp - 8'd1;
    near_zero = (cxp > weff) || (cyp == 8'd0) || (cyp > heff);
    interp_ok = interp_q && (per_q || (ix != 8'd0)) && (ix < weff) &&
                (iy != 8'd0) && (iy < heff);
    left = (ix == 8'd0) ? weff - 8'd1 : ix - 8'd1;
  end

  logic [6:0]  sel_row, sel_col;
  logic [8:0]  sel_a, sel_b;

  always_comb begin
    case (k_q)
      2'd0: begin
        sel_row = row0_q; sel_col = col0_q; sel_a = ta_q; sel_b = ua_q;
      end
      2'd1: begin
        sel_row = row0_q; sel_col = col1_q; sel_a = tb_q; sel_b = ua_q;
      end
      2'd2: begin
        sel_row = row1_q; sel_col = col1_q; sel_a = tb_q; sel_b = ub_q;
      end
      default: begin
        sel_row = row1_q; sel_col = col0_q; sel_a = ta_q; sel_b = ub_q;
      end
    endcase
  end

  assign mem_re    = (state_q == S_RD);
  assign mem_raddr = {plane_q, sel_row, sel_col};

  logic [16:0] wgt_q;
  logic [48:0] prod_q, acc_q;
  logic        p1_q, p1_last_q, p2_q, p2_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q      <= 1'b0;
      p1_last_q <= 1'b0;
      p2_q      <= 1'b0;
      p2_last_q <= 1'b0;
    end else begin
      p1_q      <= (state_q == S_RD);
      p1_last_q <= (state_q == S_RD) && (k_q == last_q);
      p2_q      <= p1_q;
      p2_last_q <= p1_q && p1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    wgt_q  <= {8'd0, sel_a} * {8'd0, sel_b};
    prod_q <= {32'd0, wgt_q} * {17'd0, rd_q};
    if (state_q == S_CHK) begin
      acc_q <= 49'd0;
    end else if (p2_q) begin
      acc_q <= acc_q + prod_q;
    end
  end

  logic out_free;
  assign out_free = !out_valid_o || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (take && (buf_q.mode == MODE_QUERY)) begin
          state_d = per_q ? S_MOD : S_CHK;
        end
      end
      S_MOD: begin
        if (mcnt_q == 3'd5) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (outside || (!interp_ok && near_zero)) begin
          state_d = S_FIN;
        end else begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        if (k_q == last_q) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (p2_q && p2_last_q) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mcnt_q  <= 3'd0;
      k_q     <= 2'd0;
    end else begin
      state_q <= state_d;
      if (state_q == S_MOD) begin
        mcnt_q <= mcnt_q + 3'd1;
      end else begin
        mcnt_q <= 3'd0;
      end
      if (state_q == S_RD) begin
        k_q <= k_q + 2'd1;
      end else begin
        k_q <= 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      plane_q <= buf_q.plane;
      xv_q    <= buf_q.coord_x;
      yv_q    <= buf_q.coord_y;
      v_q     <= {{8{buf_q.coord_x[23]}}, buf_q.coord_x[23:8]} +
                 {1'b0, weff, 15'd0};
      r_q     <= 8'd0;
    end else if (state_q == S_MOD) begin
      v_q <= {v_q[19:0], 4'd0};
      r_q <= r_next;
      if (mcnt_q == 3'd5) begin
        xv_q <= {8'd0, r_next, xv_q[7:0]};
      end
    end
    if (state_q == S_CHK) begin
      res_out_q  <= outside;
      res_zero_q <= outside || (!interp_ok && near_zero);
      if (interp_ok) begin
        row0_q <= 7'(iy - 8'd1);
        row1_q <= iy[6:0];
        col0_q <= left[6:0];
        col1_q <= ix[6:0];
        ta_q   <= 9'd256 - {1'b0, xs[7:0]};
        tb_q   <= {1'b0, xs[7:0]};
        ua_q   <= 9'd256 - {1'b0, ys[7:0]};
        ub_q   <= {1'b0, ys[7:0]};
        last_q <= 2'd3;
      end else begin
        row0_q <= 7'(cyp - 8'd1);
        row1_q <= 7'(cyp - 8'd1);
        col0_q <= cx[6:0];
        col1_q <= cx[6:0];
        ta_q   <= 9'd256;
        tb_q   <= 9'd256;
        ua_q   <= 9'd256;
        ub_q   <= 9'd256;
        last_q <= 2'd0;
      end
    end
  end

  logic [48:0] rounded;
  assign rounded = acc_q + 49'd32768;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if ((state_q == S_FIN) && out_free) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_FIN) && out_free) begin
      out_item_o.map_value   <= res_zero_q ? 32'd0 : rounded[47:16];
      out_item_o.outside_map <= res_out_q;
    end
  end

endmodule

/* src/imbl_checker.sv */
module imbl_checker
  import imbl_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input out_item_t  out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("result changed while stalled");

  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.outside_map |-> out_item_o.map_value == 32'd0)
    else $error("outside result with nonzero value");

  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({in_stall_o, out_valid_o}))
    else $error("handshake output unknown");

endmodule

bind image_map_bilinear_lookup_top imbl_checker u_imbl_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_o (out_item_o)
);

/* bench/image_map_bilinear_lookup_top_test.sv */
`timescale 1ns / 1ps

module image_map_bilinear_lookup_top_test;
  import imbl_pkg::*;

  localparam int MAX_CYCLES = 2000000;
  localparam int RAND_ITEMS = 720;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_index_i;
  logic [7:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_stall_o;
  in_item_t   in_item_i;
  logic       out_valid_o;
  logic       out_stall_i;
  out_item_t  out_item_o;

  image_map_bilinear_lookup_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // predictor copy of the block state
  logic [31:0] pixels [int];
  logic [7:0]  width_reg;
  logic [7:0]  height_reg;
  logic        periodic_reg;
  logic        interp_reg;

  out_item_t lookup_q [$];
  int        mismatches;
  int        cycles;
  bit        long_hold;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int px_key(int p, int r, int c);
    return (p * MAX_ROWS + r) * MAX_COLS + c;
  endfunction

  function automatic logic [31:0] px_read(int p, int r, int c);
    int k;
    k = px_key(p, r, c);
    if (pixels.exists(k)) return pixels[k];
    return 32'd0;
  endfunction

  function automatic int eff_width();
    if (width_reg < 1) return 1;
    if (width_reg > MAX_COLS) return MAX_COLS;
    return int'(width_reg);
  endfunction

  function automatic int eff_height();
    if (height_reg < 1) return 1;
    if (height_reg > MAX_ROWS) return MAX_ROWS;
    return int'(height_reg);
  endfunction

  function automatic logic [31:0] nearest_px(longint x, longint y, int p, int w, int h);
    longint cx;
    longint cy;
    cx = ((x + 128) >>> FRAC_BITS) - 1;
    cy = ((y + 128) >>> FRAC_BITS) - 1;
    if ((!periodic_reg && (cx < 0 || cx >= w)) || cy < 0 || cy >= h) return 32'd0;
    if (cx < 0) cx = 0;
    if (cx >= w) return 32'd0;
    return px_read(p, int'(cy), int'(cx));
  endfunction

  function automatic out_item_t lookup_value(in_item_t it);
    out_item_t r;
    int w;
    int h;
    int pl;
    longint x;
    longint y;
    longint ix;
    longint iy;
    longint span;
    longint tt;
    longint uu;
    int lft;
    logic [63:0] acc;
    w = eff_width();
    h = eff_height();
    pl = int'(it.plane);
    r = '0;
    x = longint'(it.coord_x);
    y = longint'(it.coord_y);
    if (periodic_reg) begin
      span = longint'(w) * 256;
      x = x % span;
      if (x < 0) x += span;
    end
    if ((!periodic_reg && (x < 128 || x > longint'(w) * 256 + 128)) ||
        y < 128 || y > longint'(h) * 256 + 128) begin
      r.outside_map = 1'b1;
      return r;
    end
    if (!interp_reg) begin
      r.map_value = nearest_px(x, y, pl, w, h);
      return r;
    end
    ix = x >>> FRAC_BITS;
    iy = y >>> FRAC_BITS;
    if ((!periodic_reg && (ix < 1 || ix >= w)) || iy < 1 || iy >= h || ix >= w) begin
      r.map_value = nearest_px(x, y, pl, w, h);
      return r;
    end
    tt = x & 255;
    uu = y & 255;
    lft = (ix == 0) ? w - 1 : int'(ix - 1);
    acc = 64'(256 - tt) * 64'(256 - uu) * 64'(px_read(pl, int'(iy - 1), lft))
        + 64'(tt) * 64'(256 - uu) * 64'(px_read(pl, int'(iy - 1), int'(ix)))
        + 64'(tt) * 64'(uu) * 64'(px_read(pl, int'(iy), int'(ix)))
        + 64'(256 - tt) * 64'(uu) * 64'(px_read(pl, int'(iy), lft));
    acc += 64'd32768;
    r.map_value = acc[47:16];
    return r;
  endfunction

  task automatic cfg_write(cfg_index_e idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MAP_WIDTH:   width_reg = val;
      CFG_MAP_HEIGHT:  height_reg = val;
      CFG_PERIODIC:    periodic_reg = val[0];
      default:         interp_reg = val[0];
    endcase
  endtask

  task automatic send_item(in_item_t it, bit has_exp, out_item_t exp_val);
    int gap;
    gap = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(5, 40);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (it.mode == MODE_WRITE) begin
      if (it.plane < PLANES) begin
        pixels[px_key(int'(it.plane), int'(it.write_row), int'(it.write_col))] =
          it.write_value;
      end
    end else if (has_exp) begin
      lookup_q = {lookup_q, exp_val};
    end else begin
      lookup_q = {lookup_q, lookup_value(it)};
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (lookup_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  function automatic in_item_t pix_item(int p, int r, int c, logic [31:0] v);
    in_item_t it;
    it = '0;
    it.mode = MODE_WRITE;
    it.plane = 2'(p);
    it.write_row = 7'(r);
    it.write_col = 7'(c);
    it.write_value = v;
    it.coord_x = 24'($urandom);
    it.coord_y = 24'($urandom);
    return it;
  endfunction

  function automatic in_item_t query_item(int p, int x, int y);
    in_item_t it;
    it = '0;
    it.mode = MODE_QUERY;
    it.plane = 2'(p);
    it.coord_x = 24'(x);
    it.coord_y = 24'(y);
    it.write_col = 7'($urandom);
    it.write_row = 7'($urandom);
    it.write_value = $urandom;
    return it;
  endfunction

  // fill rows/cols in use of the given planes so that no read hits an unwritten pixel
  task automatic fill_map(int p_first, int p_last, int w, int h, bit extremes);
    logic [31:0] v;
    for (int p = p_first; p <= p_last; p++)
      for (int r = 0; r < h; r++)
        for (int c = 0; c < w; c++) begin
          if (extremes) v = ((r + c + p) % 2) ? 32'hFFFF_FFFF : 32'd0;
          else v = $urandom;
          send_item(pix_item(p, r, c, v), 1'b0, '0);
        end
  endtask

  function automatic int rand_coord(int span_px);
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return int'($urandom) % 8388608 * (($urandom_range(0, 1)) ? 1 : -1);
    if (k == 1) return $urandom_range(0, 300) - 150;
    return $urandom_range(0, span_px * 256 + 300) - 100;
  endfunction

  // directed rows: plane, x, y, has expected, expected value, expected flag
  typedef struct {
    int p;
    int x;
    int y;
    bit known;
    logic [31:0] v;
    bit f;
  } dir_row_t;

  dir_row_t dir_rows [$];

  initial begin : stimulus
    int w;
    int h;
    int qp;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_MAP_WIDTH;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    width_reg = 8'd128;
    height_reg = 8'd128;
    periodic_reg = 1'b0;
    interp_reg = 1'b1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part on a small map, queried at reset settings after sizing down
    cfg_write(CFG_MAP_WIDTH, 8'd4);
    cfg_write(CFG_MAP_HEIGHT, 8'd3);
    fill_map(0, PLANES - 1, 4, 3, 1'b1);
    send_item(pix_item(1, 127, 127, 32'hFFFF_FFFF), 1'b0, '0);
    dir_rows = '{
      '{0, 256, 256, 1'b1, 32'd0, 1'b0},
      '{0, 512, 256, 1'b1, 32'hFFFF_FFFF, 1'b0},
      '{0, 127, 256, 1'b1, 32'd0, 1'b1},
      '{0, 256, 127, 1'b1, 32'd0, 1'b1},
      '{0, -8388608, 256, 1'b1, 32'd0, 1'b1},
      '{0, 8388607, 8388607, 1'b1, 32'd0, 1'b1},
      '{0, 4 * 256 + 128, 256, 1'b1, 32'd0, 1'b0},
      '{0, 256, 3 * 256 + 128, 1'b1, 32'd0, 1'b0},
      '{3, 384, 384, 1'b0, 0, 0},
      '{2, 600, 700, 1'b0, 0, 0},
      '{1, 128, 128, 1'b0, 0, 0},
      '{1, 1000, 500, 1'b0, 0, 0}
    };
    foreach (dir_rows[i]) begin
      out_item_t e;
      e.map_value = dir_rows[i].v;
      e.outside_map = dir_rows[i].f;
      send_item(query_item(dir_rows[i].p, dir_rows[i].x, dir_rows[i].y),
                dir_rows[i].known, e);
    end
    drain();
    cfg_write(CFG_PERIODIC, 8'd1);
    foreach (dir_rows[i])
      send_item(query_item(dir_rows[i].p, dir_rows[i].x - 512, dir_rows[i].y), 1'b0, '0);
    send_item(query_item(0, 100, 300), 1'b0, '0);
    send_item(query_item(2, 50, 500), 1'b0, '0);
    drain();
    cfg_write(CFG_INTERPOLATE, 8'd0);
    send_item(query_item(0, 100, 300), 1'b0, '0);
    send_item(query_item(3, 700, 600), 1'b0, '0);
    drain();

    // random phases over several settings, one queried plane per phase
    for (int ph = 0; ph < 8; ph++) begin
      qp = ph % PLANES;
      case (ph)
        0: begin w = 1; h = 1; end
        1: begin w = 2; h = 2; end
        2: begin w = 0; h = 0; end
        3: begin w = 200; h = 3; end
        default: begin w = $urandom_range(2, 12); h = $urandom_range(2, 12); end
      endcase
      if (ph == 7) begin w = 128; h = 128; end
      drain();
      cfg_write(CFG_MAP_WIDTH, 8'(w));
      cfg_write(CFG_MAP_HEIGHT, 8'(h));
      cfg_write(CFG_PERIODIC, 8'(ph % 2));
      cfg_write(CFG_INTERPOLATE, 8'((ph / 2) % 2 == 0));
      // full map: write only rows 0..2 and keep queries in that region
      if (ph != 7) fill_map(qp, qp, eff_width(), eff_height(), 1'b0);
      else fill_map(qp, qp, 128, 3, 1'b0);
      if (ph == 4) long_hold = 1'b1;
      for (int n = 0; n < RAND_ITEMS / 8; n++) begin
        if ($urandom_range(0, 5) == 0) begin
          int rr;
          int cc;
          rr = $urandom_range(0, eff_height() - 1);
          cc = $urandom_range(0, eff_width() - 1);
          if (ph == 7) rr = $urandom_range(0, 2);
          send_item(pix_item($urandom_range(0, 3), rr, cc, $urandom), 1'b0, '0);
        end else begin
          int yy;
          yy = rand_coord(eff_height());
          if (ph == 7 && yy >= 3 * 256 - 128 && yy <= 128 * 256 + 128)
            yy = $urandom_range(128, 3 * 256 - 129);
          send_item(query_item(qp, rand_coord(eff_width()), yy), 1'b0, '0);
        end
        if (n == 50 && ph == 5) drain();
      end
    end
    drain();
    if (mismatches == 0) $display("image_map_bilinear_lookup_top test passed");
    else $display("image_map_bilinear_lookup_top test failed");
    $finish;
  end

  initial begin : receiver_stall
    int n;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        long_hold = 1'b0;
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        n = $urandom_range(0, 99);
        if (n < 60) out_stall_i <= 1'b0;
        else if (n < 95) out_stall_i <= 1'b1;
        else begin
          out_stall_i <= 1'b1;
          repeat ($urandom_range(5, 40)) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (lookup_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_item_o);
      end else begin
        out_item_t e;
        e = lookup_q.pop_front();
        if (e.map_value !== out_item_o.map_value || e.outside_map !== out_item_o.outside_map) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value %h flag %b, got value %h flag %b",
                     e.map_value, e.outside_map, out_item_o.map_value, out_item_o.outside_map);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("image_map_bilinear_lookup_top test failed");
      $finish;
    end
  end

endmodule
